### hw/rtl/page_margin_bounding_box_top_macros.svh
// ---------------------------------------------------------------------------
// Page margin bounding box assertion macros
// Concurrent assertion shorthands on clock and reset for the margin block.
// ---------------------------------------------------------------------------
`ifndef PAGE_MARGIN_BOUNDING_BOX_TOP_MACROS_SVH
`define PAGE_MARGIN_BOUNDING_BOX_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PMBB_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pmbb assertion failed");

// antecedent implies consequent in the next cycle
`define PMBB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmbb assertion failed");

`endif

### hw/rtl/pmbb_pkg.sv
// ---------------------------------------------------------------------------
// Page margin bounding box package
// Shared field widths, register indexes, reset values and bundle types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmbb_pkg;

   localparam int CHAN_W  = 8;
   localparam int DIM_W   = 14;
   localparam int THR_W   = 8;
   localparam int SCALE_W = 24;
   localparam int OUT_W   = 38;
   localparam int CSR_W   = 24;
   localparam int IDX_W   = 2;

   localparam logic [DIM_W-1:0]   WIDTH_RST  = 14'd2480;
   localparam logic [DIM_W-1:0]   HEIGHT_RST = 14'd3508;
   localparam logic [THR_W-1:0]   THR_RST    = 8'd254;
   localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd5549;

   typedef enum logic [IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_INK_THRESH   = 2'd2,
      CSR_MM_PER_PIXEL = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [THR_W-1:0]   ink_threshold;
      logic [SCALE_W-1:0] mm_per_pixel_q16;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_c;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_a;
   } pixel_type;

   typedef struct packed {
      logic take;
      logic frame_end;
   } track_stat_type;

endpackage

`default_nettype wire

### hw/rtl/page_margin_bounding_box_top.sv
// One pixel word is taken every cycle, but for the stall below; the block counts column and row
// against the configured page size and emits one result word, the four margins in
// millimetres (Q22.16), after the last pixel of each page. That last pixel passes through
// an input register, the extent tracker's margin register and the scaler's output register
// before its result appears on rsp_tvalid; the margin multipliers are combinational. While a
// result waits on rsp_tready the following page's result is held in the tracker; only the last
// pixel of the page after that stalls, and the input with it. Configuration writes take effect
// at once and are meant for idle time.
`timescale 1ns / 1ps
`default_nettype none

`include "page_margin_bounding_box_top_macros.svh"

// ---------------------------------------------------------------------------
// Page margin bounding box top level
// Input register, configuration registers, extent tracker and margin scaler.
// ---------------------------------------------------------------------------
module page_margin_bounding_box_top #(
   parameter int MAX_DIM = 8192
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
   input  wire logic [3*pmbb_pkg::CHAN_W-1:0]         req_tdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // left_mm [37:0], right_mm [75:38], top_mm [113:76], bottom_mm [151:114]
   output logic [4*pmbb_pkg::OUT_W-1:0]               rsp_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic                                  csr_wr_en,
   input  wire logic [pmbb_pkg::IDX_W-1:0]            csr_index,
   input  wire logic [pmbb_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int DW = $clog2(MAX_DIM+2);

   pmbb_pkg::cfg_type         cfg_ff, cfg_in;
   pmbb_pkg::pixel_type       pix_ff;
   logic                      pix_vld_ff, pix_vld_in;
   pmbb_pkg::track_stat_type  stat;
   logic                      mar_vld, out_free;
   logic [3:0][DW-1:0]        mar;
   logic                      req_acc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (pmbb_pkg::csr_index_type'(csr_index))
            pmbb_pkg::CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_wdata[pmbb_pkg::DIM_W-1:0];
            end
            pmbb_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_wdata[pmbb_pkg::DIM_W-1:0];
            end
            pmbb_pkg::CSR_INK_THRESH: begin
               cfg_in.ink_threshold = csr_wdata[pmbb_pkg::THR_W-1:0];
            end
            pmbb_pkg::CSR_MM_PER_PIXEL: begin
               cfg_in.mm_per_pixel_q16 = csr_wdata[pmbb_pkg::SCALE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
      req_tready = !pix_vld_ff || stat.take;
      req_acc    = req_tvalid && req_tready;
      pix_vld_in = req_acc ? 1'b1 : (stat.take ? 1'b0 : pix_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= pmbb_pkg::WIDTH_RST;
         cfg_ff.image_height     <= pmbb_pkg::HEIGHT_RST;
         cfg_ff.ink_threshold    <= pmbb_pkg::THR_RST;
         cfg_ff.mm_per_pixel_q16 <= pmbb_pkg::SCALE_RST;
         pix_vld_ff              <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         pix_vld_ff <= pix_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pix_ff <= pmbb_pkg::pixel_type'(req_tdata);
      end
   end

   pmbb_track #(
      .MAX_DIM (MAX_DIM)
   ) u_track (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .pix_vld  (pix_vld_ff),
      .pix      (pix_ff),
      .out_free (out_free),
      .stat     (stat),
      .mar_vld  (mar_vld),
      .mar      (mar)
   );

   pmbb_scale #(
      .MAX_DIM (MAX_DIM)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .scale      (cfg_ff.mm_per_pixel_q16),
      .mar_vld    (mar_vld),
      .mar        (mar),
      .rsp_tready (rsp_tready),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   `PMBB_ASSERT_NEXT(a_frame_end_loads_margin, stat.take && stat.frame_end, mar_vld)
   `PMBB_ASSERT_NEXT(a_margin_held_on_stall, mar_vld && !out_free, mar_vld)
   `PMBB_ASSERT_SAME(a_result_from_margin, $rose(rsp_tvalid), $past(mar_vld))

endmodule

`default_nettype wire

### hw/rtl/pmbb_track.sv
// ---------------------------------------------------------------------------
// Page margin bounding box tracker
// Raster counters, ink extent registers and the margin-in-pixels register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmbb_track #(
   parameter int MAX_DIM = 8192
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pmbb_pkg::cfg_type                     cfg,
   input  wire logic                                  pix_vld,
   input  wire pmbb_pkg::pixel_type                   pix,
   input  wire logic                                  out_free,
   output pmbb_pkg::track_stat_type                   stat,
   output logic                                       mar_vld,
   output logic [3:0][$clog2(MAX_DIM+2)-1:0]          mar
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM+2);

   function automatic logic [DW-1:0] eff_dim(input logic [pmbb_pkg::DIM_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DW'(MAX_DIM);
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] far_margin(input logic [CW-1:0] last,
                                                 input logic [CW-1:0] maxv);
      logic [CW-1:0] r;
      if (maxv >= last) begin
         r = '0;
      end else begin
         r = last - maxv;
      end
      return r;
   endfunction

   logic [CW-1:0]       col_ff, col_in, row_ff, row_in;
   logic [CW-1:0]       min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [CW-1:0]       min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic                ink_seen_ff, ink_seen_in;
   logic                mar_vld_ff, mar_vld_in;
   logic [3:0][DW-1:0]  mar_ff, mar_in;

   logic [DW-1:0] eff_w, eff_h;
   logic [CW-1:0] last_col, last_row;
   logic [CW-1:0] min_col_nx, max_col_nx, min_row_nx, max_row_nx;
   logic          ink, any_ink, row_end, frame_end, s2_free, take;

   always_comb begin
      eff_w     = eff_dim(cfg.image_width);
      eff_h     = eff_dim(cfg.image_height);
      last_col  = CW'(eff_w - DW'(1));
      last_row  = CW'(eff_h - DW'(1));
      ink       = (pix.chan_a < cfg.ink_threshold) && (pix.chan_b < cfg.ink_threshold)
                  && (pix.chan_c < cfg.ink_threshold);
      any_ink   = ink_seen_ff | ink;
      row_end   = col_ff >= last_col;
      frame_end = row_end && (row_ff >= last_row);
      s2_free   = !mar_vld_ff || out_free;
      take      = pix_vld && (!frame_end || s2_free);

      min_col_nx = (ink && (col_ff < min_col_ff)) ? col_ff : min_col_ff;
      max_col_nx = (ink && (col_ff > max_col_ff)) ? col_ff : max_col_ff;
      min_row_nx = (ink && (row_ff < min_row_ff)) ? row_ff : min_row_ff;
      max_row_nx = (ink && (row_ff > max_row_ff)) ? row_ff : max_row_ff;

      if (any_ink) begin
         mar_in[0] = DW'(min_col_nx);
         mar_in[1] = DW'(far_margin(last_col, max_col_nx));
         mar_in[2] = DW'(min_row_nx);
         mar_in[3] = DW'(far_margin(last_row, max_row_nx));
      end else begin
         mar_in[0] = DW'(eff_w + DW'(1));
         mar_in[1] = DW'(eff_w + DW'(1));
         mar_in[2] = DW'(eff_h + DW'(1));
         mar_in[3] = DW'(eff_h + DW'(1));
      end

      col_in      = col_ff;
      row_in      = row_ff;
      min_col_in  = min_col_ff;
      max_col_in  = max_col_ff;
      min_row_in  = min_row_ff;
      max_row_in  = max_row_ff;
      ink_seen_in = ink_seen_ff;
      if (take) begin
         if (frame_end) begin
            col_in      = '0;
            row_in      = '0;
            min_col_in  = '1;
            max_col_in  = '0;
            min_row_in  = '1;
            max_row_in  = '0;
            ink_seen_in = 1'b0;
         end else begin
            min_col_in  = min_col_nx;
            max_col_in  = max_col_nx;
            min_row_in  = min_row_nx;
            max_row_in  = max_row_nx;
            ink_seen_in = any_ink;
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + CW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      end

      mar_vld_in = s2_free ? (take && frame_end) : mar_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         min_col_ff  <= '1;
         max_col_ff  <= '0;
         min_row_ff  <= '1;
         max_row_ff  <= '0;
         ink_seen_ff <= 1'b0;
         mar_vld_ff  <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         min_col_ff  <= min_col_in;
         max_col_ff  <= max_col_in;
         min_row_ff  <= min_row_in;
         max_row_ff  <= max_row_in;
         ink_seen_ff <= ink_seen_in;
         mar_vld_ff  <= mar_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && take && frame_end) begin
         mar_ff <= mar_in;
      end
   end

   assign stat.take      = take;
   assign stat.frame_end = frame_end;
   assign mar_vld        = mar_vld_ff;
   assign mar            = mar_ff;

endmodule

`default_nettype wire

### hw/rtl/pmbb_scale.sv
// ---------------------------------------------------------------------------
// Page margin bounding box scaler
// Multiply the four pixel margins by the Q8.16 scale into the result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmbb_scale #(
   parameter int MAX_DIM = 8192
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [pmbb_pkg::SCALE_W-1:0]          scale,
   input  wire logic                                  mar_vld,
   input  wire logic [3:0][$clog2(MAX_DIM+2)-1:0]     mar,
   input  wire logic                                  rsp_tready,
   output logic                                       out_free,
   output logic                                       rsp_tvalid,
   output logic [4*pmbb_pkg::OUT_W-1:0]               rsp_tdata
);

   localparam int DW  = $clog2(MAX_DIM+2);
   localparam int PW  = DW + pmbb_pkg::SCALE_W;
   localparam int PWX = (PW > pmbb_pkg::OUT_W) ? PW : pmbb_pkg::OUT_W;

   logic                                  out_vld_ff, out_vld_in;
   logic [3:0][pmbb_pkg::OUT_W-1:0]       data_ff, data_in;
   logic [3:0][PWX-1:0]                   prod;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod[i]    = PWX'(mar[i]) * PWX'(scale);
         data_in[i] = prod[i][pmbb_pkg::OUT_W-1:0];
      end
      out_free   = !out_vld_ff || rsp_tready;
      out_vld_in = out_free ? mar_vld : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && mar_vld) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page margin bounding box testbench
// Streams pixel words through the block, first from a directed table and then
// in random register settings, and predicts each page's margin word in
// parallel. Every margin word is checked field by field in order of arrival.
// Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
   import pmbb_pkg::*;

   localparam int DIM_LIMIT     = 8192;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_ITEMS  = 800;

   typedef struct packed {
      logic [OUT_W-1:0] bottom_mm;
      logic [OUT_W-1:0] top_mm;
      logic [OUT_W-1:0] right_mm;
      logic [OUT_W-1:0] left_mm;
   } margin_set_type;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      csr_index_type  idx;
      logic [CSR_W-1:0] value;
      pixel_type      px;
      logic           typed;
      margin_set_type want;
   } step_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
   logic [3*CHAN_W-1:0]   req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // left_mm [37:0], right_mm [75:38], top_mm [113:76], bottom_mm [151:114]
   logic [4*OUT_W-1:0]    rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en  = 1'b0;
   csr_index_type         csr_index  = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   page_margin_bounding_box_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow registers and page tracker state
   logic [DIM_W-1:0]   cfg_width  = WIDTH_RST;
   logic [DIM_W-1:0]   cfg_height = HEIGHT_RST;
   logic [THR_W-1:0]   cfg_thresh = THR_RST;
   logic [SCALE_W-1:0] cfg_scale  = SCALE_RST;
   logic [12:0]        col_at, row_at, ink_col_lo, ink_col_hi, ink_row_lo, ink_row_hi;
   bit                 page_inked;

   margin_set_type     page_q [$];
   step_row_type       plan [$];
   int                 pixels_sent, pages_checked, settings_seen, fail_count;
   bit                 no_gaps, steady_sink;
   int                 sink_wait;
   margin_set_type     got, want;

   function automatic void clear_page();
      col_at     = '0;
      row_at     = '0;
      page_inked = 1'b0;
      ink_col_lo = '1;
      ink_col_hi = '0;
      ink_row_lo = '1;
      ink_row_hi = '0;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 14'd1;
      if (v > DIM_LIMIT) return 14'(DIM_LIMIT);
      return v;
   endfunction

   function automatic logic [OUT_W-1:0] to_mm(logic [DIM_W-1:0] px);
      logic [63:0] prod;
      prod = 64'(px) * 64'(cfg_scale);
      return prod[OUT_W-1:0];
   endfunction

   function automatic logic [DIM_W-1:0] far_gap(logic [DIM_W-1:0] dim, logic [12:0] hi);
      if ({1'b0, hi} >= dim - 14'd1) return '0;
      return dim - 14'd1 - {1'b0, hi};
   endfunction

   function automatic bit track_pixel(pixel_type px, output margin_set_type m);
      logic [DIM_W-1:0] w, h;
      bit row_done, page_done;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      row_done  = {1'b0, col_at} >= w - 14'd1;
      page_done = row_done && ({1'b0, row_at} >= h - 14'd1);
      m = '0;
      if (px.chan_a < cfg_thresh && px.chan_b < cfg_thresh && px.chan_c < cfg_thresh) begin
         page_inked = 1'b1;
         if (col_at < ink_col_lo) ink_col_lo = col_at;
         if (col_at > ink_col_hi) ink_col_hi = col_at;
         if (row_at < ink_row_lo) ink_row_lo = row_at;
         if (row_at > ink_row_hi) ink_row_hi = row_at;
      end
      if (page_done) begin
         if (page_inked) begin
            m.left_mm   = to_mm({1'b0, ink_col_lo});
            m.right_mm  = to_mm(far_gap(w, ink_col_hi));
            m.top_mm    = to_mm({1'b0, ink_row_lo});
            m.bottom_mm = to_mm(far_gap(h, ink_row_hi));
         end else begin
            m.left_mm   = to_mm(w + 14'd1);
            m.right_mm  = to_mm(w + 14'd1);
            m.top_mm    = to_mm(h + 14'd1);
            m.bottom_mm = to_mm(h + 14'd1);
         end
         clear_page();
         return 1'b1;
      end
      if (row_done) begin
         col_at = '0;
         row_at = row_at + 13'd1;
      end else begin
         col_at = col_at + 13'd1;
      end
      return 1'b0;
   endfunction

   function automatic step_row_type csr_row(csr_index_type idx, logic [CSR_W-1:0] val);
      step_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.value = val;
      return r;
   endfunction

   function automatic step_row_type pix_row(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      step_row_type r;
      r      = '0;
      r.kind = ROW_PIXEL;
      r.px   = {c, b, a};
      return r;
   endfunction

   // left and right share one value, top and bottom the other
   function automatic step_row_type pix_want(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                             logic [OUT_W-1:0] lr, logic [OUT_W-1:0] tb);
      step_row_type r;
      r       = pix_row(a, b, c);
      r.typed = 1'b1;
      r.want  = '{bottom_mm: tb, top_mm: tb, right_mm: lr, left_mm: lr};
      return r;
   endfunction

   function automatic pixel_type make_pixel(int ink_pct);
      pixel_type px;
      int        thr;
      thr = int'(cfg_thresh);
      px  = pixel_type'(24'($urandom));
      if ($urandom_range(0, 99) < ink_pct && thr != 0) begin
         px.chan_a = 8'($urandom_range(0, thr - 1));
         px.chan_b = 8'($urandom_range(0, thr - 1));
         px.chan_c = 8'($urandom_range(0, thr - 1));
      end else if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 2))
            0: px.chan_a = 8'($urandom_range(thr, 255));
            1: px.chan_b = 8'($urandom_range(thr, 255));
            default: px.chan_c = 8'($urandom_range(thr, 255));
         endcase
      end
      return px;
   endfunction

   // drop valid and wait until every margin word is back and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (page_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] val, bit last);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = val[DIM_W-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = val[DIM_W-1:0];
         CSR_INK_THRESH:   cfg_thresh = val[THR_W-1:0];
         CSR_MM_PER_PIXEL: cfg_scale  = val[SCALE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      if (last) csr_wr_en <= 1'b0;
   endtask

   task automatic push_pixel(pixel_type px, bit typed, margin_set_type typed_want);
      int             gap;
      margin_set_type m;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= px;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      if (track_pixel(px, m)) page_q.insert(page_q.size(), typed ? typed_want : m);
      @(negedge clock);
   endtask

   task automatic run_phase(logic [CSR_W-1:0] w, logic [CSR_W-1:0] h, logic [CSR_W-1:0] thr,
                            logic [CSR_W-1:0] scl, int ink_pct, int count);
      settle();
      write_csr(CSR_IMAGE_WIDTH, w, 1'b0);
      write_csr(CSR_IMAGE_HEIGHT, h, 1'b0);
      write_csr(CSR_INK_THRESH, thr, 1'b0);
      write_csr(CSR_MM_PER_PIXEL, scl, 1'b1);
      settings_seen++;
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (count) begin
         if ($urandom_range(0, 99) == 0) settle();
         push_pixel(make_pixel(ink_pct), 1'b0, '0);
      end
   endtask

   function automatic logic [CSR_W-1:0] pick_dim();
      logic [DIM_W-1:0] d;
      case ($urandom_range(0, 15))
         0:                  d = '0;
         13, 14, 15:         d = 14'($urandom_range(5, 12));
         default:            d = 14'($urandom_range(1, 4));
      endcase
      return {($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0, d};
   endfunction

   task automatic check_field(string name, logic [OUT_W-1:0] exp_val, logic [OUT_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s expected %0d actual %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // margin word checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         pages_checked++;
         if (page_q.size() == 0) begin
            $error("margin word with no page pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = page_q.pop_front();
            check_field("left_mm", want.left_mm, got.left_mm);
            check_field("right_mm", want.right_mm, got.right_mm);
            check_field("top_mm", want.top_mm, got.top_mm);
            check_field("bottom_mm", want.bottom_mm, got.bottom_mm);
         end
         if ($urandom_range(0, 15) == 0) steady_sink = !steady_sink;
         sink_wait <= steady_sink ? 0 : $urandom_range(0, 5);
      end else if (sink_wait > 0) begin
         sink_wait <= sink_wait - 1;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= (sink_wait == 0);
   end

   initial begin
      #20_000_000;
      $display("FAIL page_margin_bounding_box_top");
      $finish;
   end

   initial begin
      int               area, ink_pct;
      logic [CSR_W-1:0] w, h, thr, scl;
      clear_page();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // threshold and scale still hold their reset values in the first rows
      plan = '{
         csr_row(CSR_IMAGE_WIDTH, 24'd1),
         csr_row(CSR_IMAGE_HEIGHT, 24'd1),
         pix_want(8'd0, 8'd0, 8'd0, 0, 0),
         pix_want(8'd255, 8'd255, 8'd255, 11098, 11098),
         pix_want(8'd253, 8'd253, 8'd253, 0, 0),
         pix_want(8'd254, 8'd0, 8'd0, 11098, 11098),
         pix_want(8'd0, 8'd254, 8'd0, 11098, 11098),
         pix_want(8'd0, 8'd0, 8'd254, 11098, 11098),
         csr_row(CSR_INK_THRESH, 24'd0),
         csr_row(CSR_MM_PER_PIXEL, 24'h010000),
         pix_want(8'd0, 8'd0, 8'd0, 131072, 131072),
         csr_row(CSR_INK_THRESH, 24'd255),
         pix_want(8'd254, 8'd254, 8'd254, 0, 0),
         pix_want(8'd255, 8'd255, 8'd255, 131072, 131072),
         csr_row(CSR_MM_PER_PIXEL, 24'hFFFFFF),
         pix_want(8'd255, 8'd255, 8'd255, 33554430, 33554430),
         pix_want(8'd0, 8'd0, 8'd0, 0, 0),
         csr_row(CSR_MM_PER_PIXEL, 24'd0),
         pix_want(8'd255, 8'd255, 8'd255, 0, 0),
         csr_row(CSR_IMAGE_WIDTH, 24'd0),
         csr_row(CSR_IMAGE_HEIGHT, 24'd0),
         csr_row(CSR_MM_PER_PIXEL, 24'h010000),
         pix_want(8'd0, 8'd0, 8'd0, 0, 0),
         pix_want(8'd255, 8'd255, 8'd255, 131072, 131072),
         csr_row(CSR_IMAGE_WIDTH, 24'd3),
         csr_row(CSR_IMAGE_HEIGHT, 24'd2),
         pix_row(8'd255, 8'd255, 8'd255),
         pix_row(8'd10, 8'd20, 8'd30),
         pix_row(8'd255, 8'd255, 8'd255),
         pix_row(8'd255, 8'd0, 8'd0),
         pix_row(8'd255, 8'd255, 8'd255),
         pix_row(8'd200, 8'd255, 8'd255),
         csr_row(CSR_IMAGE_WIDTH, 24'd4),
         pix_row(8'd255, 8'd255, 8'd255),
         pix_row(8'd255, 8'd255, 8'd255),
         pix_row(8'd255, 8'd255, 8'd255),
         pix_row(8'd1, 8'd2, 8'd3),
         pix_row(8'd255, 8'd255, 8'd255),
         pix_row(8'd255, 8'd255, 8'd255),
         // shrink the row mid-page: ink now lies past the last column
         csr_row(CSR_IMAGE_WIDTH, 24'd2),
         pix_row(8'd255, 8'd255, 8'd255)
      };

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (i == 0 || plan[i-1].kind != ROW_CSR) settle();
            write_csr(plan[i].idx, plan[i].value,
                      i + 1 == plan.size() || plan[i+1].kind != ROW_CSR);
         end else begin
            push_pixel(plan[i].px, plan[i].typed, plan[i].want);
         end
      end

      while (pixels_sent < RANDOM_ITEMS) begin
         w = pick_dim();
         h = pick_dim();
         case ($urandom_range(0, 7))
            0:       thr = 24'd0;
            1:       thr = 24'd255;
            default: thr = 24'($urandom_range(1, 255));
         endcase
         case ($urandom_range(0, 7))
            0:          scl = 24'd0;
            1:          scl = 24'hFFFFFF;
            2, 3, 4:    scl = 24'($urandom);
            default:    scl = 24'($urandom_range(1, 131072));
         endcase
         case ($urandom_range(0, 3))
            0:       ink_pct = 0;
            1:       ink_pct = 10;
            2:       ink_pct = 40;
            default: ink_pct = 75;
         endcase
         area = int'(clamp_dim(w[DIM_W-1:0])) * int'(clamp_dim(h[DIM_W-1:0]));
         run_phase(w, h, thr, scl, ink_pct,
                   $urandom_range(1, 3) * area + $urandom_range(0, area - 1));
      end

      // oversized row, then oversized height, the one page closed at last by shrinking the size
      run_phase(24'd16383, 24'd1, 24'($urandom_range(1, 255)), 24'hFFFFFF, 5, 120);
      run_phase(24'd3, 24'd16383, 24'd200, 24'd5549, 5, 120);
      run_phase(24'd1, 24'd1, 24'd200, 24'hFFFFFF, 20, 12);

      settle();
      $display("Covered %0d pixel words and %0d margin words over %0d register settings,",
               pixels_sent, pages_checked, settings_seen);
      $display("with blank pages, edge thresholds and scales, and oversized page sizes.");
      if (fail_count == 0) begin
         $display("PASS page_margin_bounding_box_top");
      end else begin
         $display("FAIL page_margin_bounding_box_top");
      end
      $finish;
   end

endmodule
